FILE: rtl/twfa_pkg.sv
package twfa_pkg;

  localparam int ROTATION_STEPS_DEF = 16;
  localparam int MAX_TABLE_STEPS    = 24;

  // datapath widths: components in knots * 2^16, angles in 1/65536 degree
  localparam int CW = 37;
  localparam int ZW = 25;
  localparam int MW = CW - 1;

  localparam int INV_GAIN     = 39797;
  localparam int FULL_TURN    = 360;
  localparam int HALF_TURN    = 180;
  localparam int QUARTER_TURN = 90;
  localparam int DEG_SHIFT    = 16;
  localparam int OUT_WRAP     = 23040;
  localparam int SPEED_MAX    = 131071;
  localparam int MAX_AGE_RST  = 5000;

  typedef struct packed {
    logic        ok;
    logic        left;
    logic        back;
    logic        tx_neg;
    logic        ty_neg;
    logic        zero;
    logic [15:0] sog;
  } twfa_side_t;

  // arctan(2^-i) in 1/65536 degree
  function automatic logic [ZW-1:0] atan_q16(input int idx);
    logic [ZW-1:0] v;
    unique case (idx)
      0:       v = ZW'(2949120);
      1:       v = ZW'(1740967);
      2:       v = ZW'(919879);
      3:       v = ZW'(466945);
      4:       v = ZW'(234379);
      5:       v = ZW'(117304);
      6:       v = ZW'(58666);
      7:       v = ZW'(29335);
      8:       v = ZW'(14668);
      9:       v = ZW'(7334);
      10:      v = ZW'(3667);
      11:      v = ZW'(1833);
      12:      v = ZW'(917);
      13:      v = ZW'(458);
      14:      v = ZW'(229);
      15:      v = ZW'(115);
      16:      v = ZW'(57);
      17:      v = ZW'(29);
      18:      v = ZW'(14);
      19:      v = ZW'(7);
      20:      v = ZW'(4);
      21:      v = ZW'(2);
      22:      v = ZW'(1);
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

FILE: rtl/twfa_if.sv
interface twfa_in_if;
  logic        valid;
  logic        ready;
  logic [15:0] wind_speed;
  logic [8:0]  wind_angle;
  logic [15:0] ground_speed;
  logic        wind_present;
  logic        ground_speed_present;
  logic        course_present;
  logic [15:0] wind_age;
  logic [15:0] gps_age;

  modport source (
    output valid, wind_speed, wind_angle, ground_speed, wind_present,
           ground_speed_present, course_present, wind_age, gps_age,
    input  ready
  );
  modport sink (
    input  valid, wind_speed, wind_angle, ground_speed, wind_present,
           ground_speed_present, course_present, wind_age, gps_age,
    output ready
  );
endinterface

interface twfa_out_if;
  logic        valid;
  logic        ready;
  logic        result_valid;
  logic [16:0] true_speed;
  logic [14:0] true_angle;

  modport source (output valid, result_valid, true_speed, true_angle, input ready);
  modport sink   (input valid, result_valid, true_speed, true_angle, output ready);
endinterface

FILE: rtl/twfa_front.sv
module twfa_front (
  input  logic                           clk,
  input  logic                           rst_n,
  twfa_in_if.sink                        in_word,
  input  logic [15:0]                    max_age,
  output logic                           vld_o,
  input  logic                           rdy_i,
  output logic signed [twfa_pkg::CW-1:0] x_o,
  output logic signed [twfa_pkg::ZW-1:0] z_o,
  output twfa_pkg::twfa_side_t           side_o
);
  import twfa_pkg::*;

  logic                 vld_r;
  logic signed [CW-1:0] x_r;
  logic signed [ZW-1:0] z_r;
  twfa_side_t           side_r;
  twfa_side_t           side_nxt;
  logic [8:0]           ang_a;
  logic [8:0]           ang_m;
  logic [8:0]           ang_b;
  logic                 left;
  logic                 back;
  logic [31:0]          prod;
  logic                 take;

  // fold the angle into the first quadrant, remember the mirror flags
  always_comb begin
    ang_a = (in_word.wind_angle >= 9'(FULL_TURN)) ? in_word.wind_angle - 9'(FULL_TURN)
                                                  : in_word.wind_angle;
    left  = ang_a > 9'(HALF_TURN);
    ang_m = left ? 9'(FULL_TURN) - ang_a : ang_a;
    back  = ang_m > 9'(QUARTER_TURN);
    ang_b = back ? 9'(HALF_TURN) - ang_m : ang_m;
    prod  = 32'(in_word.wind_speed) * 32'(INV_GAIN);

    side_nxt        = '0;
    side_nxt.ok     = in_word.wind_present && in_word.ground_speed_present &&
                      in_word.course_present && (in_word.wind_age <= max_age) &&
                      (in_word.gps_age <= max_age);
    side_nxt.left   = left;
    side_nxt.back   = back;
    side_nxt.sog    = in_word.ground_speed;
  end

  assign take          = !vld_r || rdy_i;
  assign in_word.ready = take;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (take) begin
      vld_r <= in_word.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (take && in_word.valid) begin
      x_r    <= signed'(CW'(prod));
      z_r    <= signed'(ZW'({ang_b, 16'b0}));
      side_r <= side_nxt;
    end
  end

  assign vld_o  = vld_r;
  assign x_o    = x_r;
  assign z_o    = z_r;
  assign side_o = side_r;

endmodule

FILE: rtl/twfa_cell.sv
module twfa_cell #(
  parameter int STEP   = 0,
  parameter bit VECTOR = 1'b0
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_vld,
  output logic                           in_rdy,
  input  logic signed [twfa_pkg::CW-1:0] in_x,
  input  logic signed [twfa_pkg::CW-1:0] in_y,
  input  logic signed [twfa_pkg::ZW-1:0] in_z,
  input  twfa_pkg::twfa_side_t           in_side,
  output logic                           out_vld,
  input  logic                           out_rdy,
  output logic signed [twfa_pkg::CW-1:0] out_x,
  output logic signed [twfa_pkg::CW-1:0] out_y,
  output logic signed [twfa_pkg::ZW-1:0] out_z,
  output twfa_pkg::twfa_side_t           out_side
);
  import twfa_pkg::*;

  logic                 vld_r;
  logic signed [CW-1:0] x_r;
  logic signed [CW-1:0] y_r;
  logic signed [ZW-1:0] z_r;
  twfa_side_t           side_r;
  logic signed [CW-1:0] dx;
  logic signed [CW-1:0] dy;
  logic signed [ZW-1:0] at;
  logic                 pos;
  logic signed [CW-1:0] x_nxt;
  logic signed [CW-1:0] y_nxt;
  logic signed [ZW-1:0] z_nxt;

  // rotation steers z toward zero, vectoring steers y toward zero
  always_comb begin
    dx    = in_y >>> STEP;
    dy    = in_x >>> STEP;
    at    = signed'(atan_q16(STEP));
    pos   = VECTOR ? in_y[CW-1] : !in_z[ZW-1];
    x_nxt = pos ? in_x - dx : in_x + dx;
    y_nxt = pos ? in_y + dy : in_y - dy;
    z_nxt = pos ? in_z - at : in_z + at;
  end

  assign in_rdy = !vld_r || out_rdy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (in_rdy) begin
      vld_r <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (in_rdy && in_vld) begin
      x_r    <= x_nxt;
      y_r    <= y_nxt;
      z_r    <= z_nxt;
      side_r <= in_side;
    end
  end

  assign out_vld  = vld_r;
  assign out_x    = x_r;
  assign out_y    = y_r;
  assign out_z    = z_r;
  assign out_side = side_r;

endmodule

FILE: rtl/twfa_join.sv
module twfa_join (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           vld_i,
  output logic                           rdy_o,
  input  logic signed [twfa_pkg::CW-1:0] c_i,
  input  logic signed [twfa_pkg::CW-1:0] s_i,
  input  twfa_pkg::twfa_side_t           side_i,
  output logic                           vld_o,
  input  logic                           rdy_i,
  output logic signed [twfa_pkg::CW-1:0] ux_o,
  output logic signed [twfa_pkg::CW-1:0] uy_o,
  output twfa_pkg::twfa_side_t           side_o
);
  import twfa_pkg::*;

  logic                 v1_r;
  logic                 v2_r;
  logic                 s1_rdy;
  logic                 s2_rdy;
  logic signed [CW-1:0] sogx;
  logic signed [CW-1:0] tx_nxt;
  logic signed [CW-1:0] ty_nxt;
  logic signed [CW-1:0] tx_r;
  logic signed [CW-1:0] ty_r;
  twfa_side_t           side1_r;
  twfa_side_t           side2_nxt;
  twfa_side_t           side2_r;
  logic signed [CW-1:0] ux_r;
  logic signed [CW-1:0] uy_r;

  // unmirror the rotated wind and take boat speed off the forward part
  always_comb begin
    sogx   = signed'(CW'({side_i.sog, 16'b0}));
    tx_nxt = side_i.left ? -s_i : s_i;
    ty_nxt = side_i.back ? (-c_i - sogx) : (c_i - sogx);
  end

  always_comb begin
    side2_nxt        = side1_r;
    side2_nxt.tx_neg = tx_r[CW-1];
    side2_nxt.ty_neg = ty_r[CW-1];
    side2_nxt.zero   = (tx_r == '0) && (ty_r == '0);
  end

  assign s2_rdy = !v2_r || rdy_i;
  assign s1_rdy = !v1_r || s2_rdy;
  assign rdy_o  = s1_rdy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else begin
      if (s1_rdy) begin
        v1_r <= vld_i;
      end
      if (s2_rdy) begin
        v2_r <= v1_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_rdy && vld_i) begin
      tx_r    <= tx_nxt;
      ty_r    <= ty_nxt;
      side1_r <= side_i;
    end
    if (s2_rdy && v1_r) begin
      ux_r    <= ty_r[CW-1] ? -ty_r : ty_r;
      uy_r    <= tx_r[CW-1] ? -tx_r : tx_r;
      side2_r <= side2_nxt;
    end
  end

  assign vld_o  = v2_r;
  assign ux_o   = ux_r;
  assign uy_o   = uy_r;
  assign side_o = side2_r;

endmodule

FILE: rtl/twfa_back.sv
module twfa_back (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           vld_i,
  output logic                           rdy_o,
  input  logic signed [twfa_pkg::CW-1:0] mag_i,
  input  logic signed [twfa_pkg::ZW-1:0] theta_i,
  input  twfa_pkg::twfa_side_t           side_i,
  twfa_out_if.source                     out_word
);
  import twfa_pkg::*;

  localparam logic [ZW-1:0] QUARTER_Q = ZW'(QUARTER_TURN * 65536);
  localparam logic [ZW-1:0] HALF_Q    = ZW'(HALF_TURN * 65536);
  localparam logic [ZW-1:0] FULL_Q    = ZW'(FULL_TURN * 65536);

  logic                 v1_r;
  logic                 v2_r;
  logic                 s1_rdy;
  logic                 s2_rdy;
  logic [ZW-1:0]        th;
  logic [ZW-1:0]        phi_nxt;
  logic [MW-1:0]        mag;
  logic [MW+15:0]       prod_nxt;
  logic [MW+15:0]       prod_r;
  logic [ZW-1:0]        phi_r;
  logic                 ok1_r;
  logic                 blank1_r;
  logic [MW+15:0]       spd_sum;
  logic [MW-1:0]        spd_full;
  logic [16:0]          spd;
  logic [ZW-1:0]        ang_sum;
  logic [14:0]          ang;
  logic                 rv_r;
  logic [16:0]          spd_r;
  logic [14:0]          ang_r;

  // quadrant from the signs of the true components
  always_comb begin
    if (theta_i[ZW-1]) begin
      th = '0;
    end else if (unsigned'(theta_i) > QUARTER_Q) begin
      th = QUARTER_Q;
    end else begin
      th = unsigned'(theta_i);
    end
    if (!side_i.ty_neg) begin
      phi_nxt = side_i.tx_neg ? FULL_Q - th : th;
    end else begin
      phi_nxt = side_i.tx_neg ? HALF_Q + th : HALF_Q - th;
    end
    mag      = mag_i[CW-1] ? '0 : mag_i[MW-1:0];
    prod_nxt = (MW+16)'(mag) * (MW+16)'(INV_GAIN);
  end

  // round, saturate, wrap
  always_comb begin
    spd_sum  = prod_r + (MW+16)'(32768);
    spd_full = spd_sum[MW+15:16];
    spd      = (spd_full > MW'(SPEED_MAX)) ? 17'(SPEED_MAX) : spd_full[16:0];
    ang_sum  = phi_r + ZW'(512);
    ang      = ang_sum[24:10];
    if (ang >= 15'(OUT_WRAP)) begin
      ang = '0;
    end
  end

  assign s2_rdy = !v2_r || out_word.ready;
  assign s1_rdy = !v1_r || s2_rdy;
  assign rdy_o  = s1_rdy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else begin
      if (s1_rdy) begin
        v1_r <= vld_i;
      end
      if (s2_rdy) begin
        v2_r <= v1_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_rdy && vld_i) begin
      prod_r   <= prod_nxt;
      phi_r    <= phi_nxt;
      ok1_r    <= side_i.ok;
      blank1_r <= !side_i.ok || side_i.zero;
    end
    if (s2_rdy && v1_r) begin
      rv_r  <= ok1_r;
      spd_r <= blank1_r ? '0 : spd;
      ang_r <= blank1_r ? '0 : ang;
    end
  end

  assign out_word.valid        = v2_r;
  assign out_word.result_valid = rv_r;
  assign out_word.true_speed   = spd_r;
  assign out_word.true_angle   = ang_r;

endmodule

FILE: rtl/true_wind_from_apparent_core.sv
// Throughput: one word per cycle while the output is not stalled;
// every stage is a registered CORDIC cell or stage.
// Each stage holds its own valid bit, so bubbles fill in while the output stalls.
// Reset: synchronous active-low rst_n clears all stage valids and loads max_age
// with 5000 ms; datapath registers are not reset.
module true_wind_from_apparent_core #(
  parameter int ROTATION_STEPS = twfa_pkg::ROTATION_STEPS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  twfa_in_if.sink     in_word,
  twfa_out_if.source  out_word,
  input  logic        cfg_we,
  input  logic [15:0] cfg_wdata
);
  import twfa_pkg::*;

  // freshness limit; to be written only while idle, which the block does not enforce
  logic [15:0] max_age_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_age_r <= 16'(MAX_AGE_RST);
    end else if (cfg_we) begin
      max_age_r <= cfg_wdata;
    end
  end

  // rotation chain: (speed/gain, 0) turned by the folded angle -> (cos, sin)
  logic                 rv [ROTATION_STEPS+1];
  logic                 rr [ROTATION_STEPS+1];
  logic signed [CW-1:0] rx [ROTATION_STEPS+1];
  logic signed [CW-1:0] ry [ROTATION_STEPS+1];
  logic signed [ZW-1:0] rz [ROTATION_STEPS+1];
  twfa_side_t           rs [ROTATION_STEPS+1];

  // vectoring chain: |true wind| * gain and first-quadrant angle
  logic                 vv [ROTATION_STEPS+1];
  logic                 vr [ROTATION_STEPS+1];
  logic signed [CW-1:0] vx [ROTATION_STEPS+1];
  logic signed [CW-1:0] vy [ROTATION_STEPS+1];
  logic signed [ZW-1:0] vz [ROTATION_STEPS+1];
  twfa_side_t           vs [ROTATION_STEPS+1];

  // front: validity check, quadrant folding, inverse-gain prescale
  twfa_front u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_word(in_word),
    .max_age(max_age_r),
    .vld_o  (rv[0]),
    .rdy_i  (rr[0]),
    .x_o    (rx[0]),
    .z_o    (rz[0]),
    .side_o (rs[0])
  );

  assign ry[0] = '0;

  for (genvar g = 0; g < ROTATION_STEPS; g++) begin : g_rot
    twfa_cell #(
      .STEP  (g),
      .VECTOR(1'b0)
    ) u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .in_vld  (rv[g]),
      .in_rdy  (rr[g]),
      .in_x    (rx[g]),
      .in_y    (ry[g]),
      .in_z    (rz[g]),
      .in_side (rs[g]),
      .out_vld (rv[g+1]),
      .out_rdy (rr[g+1]),
      .out_x   (rx[g+1]),
      .out_y   (ry[g+1]),
      .out_z   (rz[g+1]),
      .out_side(rs[g+1])
    );
  end

  // join: unmirror, subtract boat speed, zero test, absolute values
  twfa_join u_join (
    .clk   (clk),
    .rst_n (rst_n),
    .vld_i (rv[ROTATION_STEPS]),
    .rdy_o (rr[ROTATION_STEPS]),
    .c_i   (rx[ROTATION_STEPS]),
    .s_i   (ry[ROTATION_STEPS]),
    .side_i(rs[ROTATION_STEPS]),
    .vld_o (vv[0]),
    .rdy_i (vr[0]),
    .ux_o  (vx[0]),
    .uy_o  (vy[0]),
    .side_o(vs[0])
  );

  assign vz[0] = '0;

  for (genvar g = 0; g < ROTATION_STEPS; g++) begin : g_vec
    twfa_cell #(
      .STEP  (g),
      .VECTOR(1'b1)
    ) u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .in_vld  (vv[g]),
      .in_rdy  (vr[g]),
      .in_x    (vx[g]),
      .in_y    (vy[g]),
      .in_z    (vz[g]),
      .in_side (vs[g]),
      .out_vld (vv[g+1]),
      .out_rdy (vr[g+1]),
      .out_x   (vx[g+1]),
      .out_y   (vy[g+1]),
      .out_z   (vz[g+1]),
      .out_side(vs[g+1])
    );
  end

  // back: full-circle angle, gain removal, rounding, output register
  twfa_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .vld_i   (vv[ROTATION_STEPS]),
    .rdy_o   (vr[ROTATION_STEPS]),
    .mag_i   (vx[ROTATION_STEPS]),
    .theta_i (vz[ROTATION_STEPS]),
    .side_i  (vs[ROTATION_STEPS]),
    .out_word(out_word)
  );

`ifndef ASSERT_OFF
  a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_word.valid && !out_word.result_valid |->
      out_word.true_speed == '0 && out_word.true_angle == '0)
    else $error("invalid word carries nonzero result");

  a_angle_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_word.valid |-> out_word.true_angle < 15'(OUT_WRAP))
    else $error("true_angle out of range");

  a_cfg_write: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_we && rst_n |=> max_age_r == $past(cfg_wdata))
    else $error("max_age write lost");

  a_front_hold: assert property (@(posedge clk) disable iff (!rst_n)
    rv[0] && !rr[0] |=> rv[0] && $stable(rx[0]) && $stable(rz[0]))
    else $error("front stage lost a word under stall");
`endif

endmodule
